FILE: rtl/dlsr_pkg.sv
// ----------------------------------------------------------------------------
// dlsr_pkg
// shared types, constants and helpers of the display list stream receiver
// ----------------------------------------------------------------------------
package dlsr_pkg;

   localparam int MAX_INSTR   = 20;
   localparam int NUM_STRINGS = 8;
   localparam int STRING_LEN  = 256;
   localparam int NBUF        = 3;
   localparam int NPARAM      = 8;

   localparam int WORD_W  = 32;
   localparam int PTR_W   = 2;
   localparam int LEN_W   = 5;
   localparam int PHASE_W = 4;
   localparam int SEL_W   = 3;
   localparam int BC_W    = 8;
   localparam int KIND_W  = 2;
   localparam int CSR_W   = 2;

   localparam int QDEPTH  = 2;
   localparam int QIDX_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // parse phases: parameter phases are 0 .. NPARAM-1
   localparam logic [PHASE_W-1:0] PH_OPCODE = PHASE_W'(NPARAM);
   localparam logic [PHASE_W-1:0] PH_SLOT   = PHASE_W'(NPARAM + 1);
   localparam logic [PHASE_W-1:0] PH_BYTES  = PHASE_W'(NPARAM + 2);

   // write kinds
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OPCODE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PARAM  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd3;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_START  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_SUBMIT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_STRING = 2'd2;

   // item commands
   localparam logic CMD_WORD  = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   // classified item travelling from front to back
   typedef struct packed {
      logic              cmd;
      logic [WORD_W-1:0] word;
      logic              is_start;
      logic              is_submit;
      logic              is_string;
      logic              is_zero;
   } entry_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(NBUF - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      ptr_dec = (p == '0) ? PTR_W'(NBUF - 1) : p - 1'b1;
   endfunction

endpackage

FILE: rtl/dlsr_front.sv
// ----------------------------------------------------------------------------
// dlsr_front
// token registers and classification of incoming items
// ----------------------------------------------------------------------------
module dlsr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_cmd,
   input  logic [dlsr_pkg::WORD_W-1:0]        req_word,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dlsr_pkg::CSR_W-1:0]         csr_index,
   input  logic [dlsr_pkg::WORD_W-1:0]        csr_data,
   input  logic                               q_ready,
   output logic                               q_push,
   output dlsr_pkg::entry_type                q_entry
);

   logic [dlsr_pkg::WORD_W-1:0] start_tok_ff,  start_tok_in;
   logic [dlsr_pkg::WORD_W-1:0] submit_tok_ff, submit_tok_in;
   logic [dlsr_pkg::WORD_W-1:0] string_tok_ff, string_tok_in;

   assign csr_ready = 1'b1;
   assign req_ready = q_ready;
   assign q_push    = req_valid & q_ready;

   always_comb begin
      start_tok_in  = start_tok_ff;
      submit_tok_in = submit_tok_ff;
      string_tok_in = string_tok_ff;
      if (csr_valid) begin
         case (csr_index)
            dlsr_pkg::CSR_START:  start_tok_in  = csr_data;
            dlsr_pkg::CSR_SUBMIT: submit_tok_in = csr_data;
            dlsr_pkg::CSR_STRING: string_tok_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_tok_ff  <= dlsr_pkg::WORD_W'(1);
         submit_tok_ff <= dlsr_pkg::WORD_W'(2);
         string_tok_ff <= dlsr_pkg::WORD_W'(3);
      end else begin
         start_tok_ff  <= start_tok_in;
         submit_tok_ff <= submit_tok_in;
         string_tok_ff <= string_tok_in;
      end
   end

   always_comb begin
      q_entry.cmd       = req_cmd;
      q_entry.word      = req_word;
      q_entry.is_start  = (req_word == start_tok_ff);
      q_entry.is_submit = (req_word == submit_tok_ff);
      q_entry.is_string = (req_word == string_tok_ff);
      q_entry.is_zero   = (req_word == '0);
   end

endmodule

FILE: rtl/dlsr_queue.sv
// ----------------------------------------------------------------------------
// dlsr_queue
// short shifting queue of classified items between front and back
// ----------------------------------------------------------------------------
module dlsr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dlsr_pkg::entry_type push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                head_valid,
   output dlsr_pkg::entry_type head
);

   dlsr_pkg::entry_type              slot_ff [dlsr_pkg::QDEPTH];
   dlsr_pkg::entry_type              slot_in [dlsr_pkg::QDEPTH];
   logic [dlsr_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic [dlsr_pkg::QCNT_W-1:0]      count_kept;

   assign push_ready = (count_ff != dlsr_pkg::QCNT_W'(dlsr_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[0];

   always_comb begin
      slot_in    = slot_ff;
      count_kept = count_ff - dlsr_pkg::QCNT_W'(pop);
      if (pop) begin
         for (int i = 0; i < dlsr_pkg::QDEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
      if (push) begin
         slot_in[count_kept[dlsr_pkg::QIDX_W-1:0]] = push_entry;
      end
      count_in = count_kept + dlsr_pkg::QCNT_W'(push);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dlsr_pkg::QCNT_W'(dlsr_pkg::QDEPTH))
      else $error("queue count beyond depth");
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");
`endif

endmodule

FILE: rtl/dlsr_back.sv
// ----------------------------------------------------------------------------
// dlsr_back
// list parser state, buffer rotation and the registered result
// ----------------------------------------------------------------------------
module dlsr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  dlsr_pkg::entry_type                head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dlsr_pkg::KIND_W-1:0]        rsp_write_kind,
   output logic [dlsr_pkg::PTR_W-1:0]         rsp_target_buffer,
   output logic [dlsr_pkg::LEN_W-1:0]         rsp_instr_slot,
   output logic [2:0]                         rsp_param_slot,
   output logic [dlsr_pkg::SEL_W-1:0]         rsp_string_slot,
   output logic [dlsr_pkg::BC_W-1:0]          rsp_char_pos,
   output logic [dlsr_pkg::WORD_W-1:0]        rsp_write_value,
   output logic                               rsp_list_committed,
   output logic                               rsp_read_advanced,
   output logic [dlsr_pkg::PTR_W-1:0]         rsp_read_buffer,
   output logic [dlsr_pkg::LEN_W-1:0]         rsp_read_count
);

   logic [dlsr_pkg::PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dlsr_pkg::PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic                         in_list_ff, in_list_in;
   logic [dlsr_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [dlsr_pkg::SEL_W-1:0]   str_sel_ff, str_sel_in;
   logic [dlsr_pkg::BC_W-1:0]    byte_cnt_ff, byte_cnt_in;
   logic [dlsr_pkg::LEN_W-1:0]   len_ff [dlsr_pkg::NBUF];
   logic [dlsr_pkg::LEN_W-1:0]   len_in [dlsr_pkg::NBUF];
   logic                         valid_ff, valid_in;

   logic [dlsr_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [dlsr_pkg::PTR_W-1:0]   tgt_ff, tgt_in;
   logic [dlsr_pkg::LEN_W-1:0]   islot_ff, islot_in;
   logic [2:0]                   pslot_ff, pslot_in;
   logic [dlsr_pkg::SEL_W-1:0]   sslot_ff, sslot_in;
   logic [dlsr_pkg::BC_W-1:0]    pos_ff, pos_in;
   logic [dlsr_pkg::WORD_W-1:0]  val_ff, val_in;
   logic                         commit_ff, commit_in;
   logic                         swap_ff, swap_in;
   logic [dlsr_pkg::PTR_W-1:0]   rbuf_ff, rbuf_in;
   logic [dlsr_pkg::LEN_W-1:0]   rcnt_ff, rcnt_in;

   logic [dlsr_pkg::PTR_W-1:0]   wl;
   logic [dlsr_pkg::LEN_W-1:0]   len_cur;
   logic                         has_room;
   logic [dlsr_pkg::BC_W:0]      bc_sum;

   assign pop = head_valid & (~valid_ff | rsp_ready);

   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      in_list_in  = in_list_ff;
      phase_in    = phase_ff;
      str_sel_in  = str_sel_ff;
      byte_cnt_in = byte_cnt_ff;
      len_in      = len_ff;
      kind_in     = dlsr_pkg::KIND_NONE;
      tgt_in      = '0;
      islot_in    = '0;
      pslot_in    = '0;
      sslot_in    = '0;
      pos_in      = '0;
      val_in      = '0;
      commit_in   = 1'b0;
      swap_in     = 1'b0;
      wl          = dlsr_pkg::ptr_inc(wr_ptr_ff);
      len_cur     = len_ff[wl];
      has_room    = (len_cur < dlsr_pkg::LEN_W'(dlsr_pkg::MAX_INSTR));
      bc_sum      = {1'b0, byte_cnt_ff} + 1'b1;

      if (head.cmd == dlsr_pkg::CMD_FRAME) begin
         if (wr_ptr_ff != rd_ptr_ff) begin
            rd_ptr_in = dlsr_pkg::ptr_inc(rd_ptr_ff);
            swap_in   = 1'b1;
         end
      end else begin
         if (!in_list_ff) begin
            if (head.is_start) begin
               // reader holds the next buffer: reuse the last committed one
               if (wl == rd_ptr_ff) begin
                  wr_ptr_in = dlsr_pkg::ptr_dec(wr_ptr_ff);
                  wl        = wr_ptr_ff;
               end
               in_list_in = 1'b1;
               phase_in   = dlsr_pkg::PH_OPCODE;
               len_in[wl] = '0;
            end
         end else if (phase_ff == dlsr_pkg::PH_OPCODE) begin
            if (head.is_submit) begin
               if (wl != rd_ptr_ff) begin
                  wr_ptr_in = wl;
                  commit_in = 1'b1;
               end
               in_list_in = 1'b0;
            end else if (head.is_string) begin
               phase_in = dlsr_pkg::PH_SLOT;
            end else begin
               if (has_room) begin
                  kind_in  = dlsr_pkg::KIND_OPCODE;
                  islot_in = len_cur;
                  val_in   = {24'd0, head.word[7:0]};
               end
               phase_in = '0;
            end
         end else if (phase_ff < dlsr_pkg::PH_OPCODE) begin
            if (has_room) begin
               kind_in  = dlsr_pkg::KIND_PARAM;
               islot_in = len_cur;
               pslot_in = phase_ff[2:0];
               val_in   = head.word;
            end
            // last parameter steps straight into the opcode phase
            phase_in = phase_ff + 1'b1;
            if (phase_in == dlsr_pkg::PH_OPCODE && has_room) begin
               len_in[wl] = len_cur + 1'b1;
            end
         end else if (phase_ff == dlsr_pkg::PH_SLOT) begin
            if (head.word[7:0] >= 8'(dlsr_pkg::NUM_STRINGS)) begin
               str_sel_in = dlsr_pkg::SEL_W'(dlsr_pkg::NUM_STRINGS - 1);
            end else begin
               str_sel_in = head.word[dlsr_pkg::SEL_W-1:0];
            end
            byte_cnt_in = '0;
            phase_in    = dlsr_pkg::PH_BYTES;
         end else begin
            kind_in  = dlsr_pkg::KIND_BYTE;
            sslot_in = str_sel_ff;
            if (bc_sum >= (dlsr_pkg::BC_W + 1)'(dlsr_pkg::STRING_LEN)) begin
               byte_cnt_in = dlsr_pkg::BC_W'(dlsr_pkg::STRING_LEN - 1);
               pos_in      = dlsr_pkg::BC_W'(dlsr_pkg::STRING_LEN - 1);
               val_in      = '0;
            end else begin
               byte_cnt_in = bc_sum[dlsr_pkg::BC_W-1:0];
               pos_in      = byte_cnt_ff;
               val_in      = {24'd0, head.word[7:0]};
            end
            if (head.is_zero) begin
               phase_in = dlsr_pkg::PH_OPCODE;
            end
         end
         tgt_in = wl;
      end

      rbuf_in = rd_ptr_in;
      rcnt_in = len_in[rd_ptr_in];

      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         in_list_ff  <= 1'b0;
         phase_ff    <= dlsr_pkg::PH_OPCODE;
         str_sel_ff  <= '0;
         byte_cnt_ff <= '0;
         for (int i = 0; i < dlsr_pkg::NBUF; i++) begin
            len_ff[i] <= '0;
         end
         valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            rd_ptr_ff   <= rd_ptr_in;
            wr_ptr_ff   <= wr_ptr_in;
            in_list_ff  <= in_list_in;
            phase_ff    <= phase_in;
            str_sel_ff  <= str_sel_in;
            byte_cnt_ff <= byte_cnt_in;
            len_ff      <= len_in;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= kind_in;
         tgt_ff    <= tgt_in;
         islot_ff  <= islot_in;
         pslot_ff  <= pslot_in;
         sslot_ff  <= sslot_in;
         pos_ff    <= pos_in;
         val_ff    <= val_in;
         commit_ff <= commit_in;
         swap_ff   <= swap_in;
         rbuf_ff   <= rbuf_in;
         rcnt_ff   <= rcnt_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_write_kind     = kind_ff;
   assign rsp_target_buffer  = tgt_ff;
   assign rsp_instr_slot     = islot_ff;
   assign rsp_param_slot     = pslot_ff;
   assign rsp_string_slot    = sslot_ff;
   assign rsp_char_pos       = pos_ff;
   assign rsp_write_value    = val_ff;
   assign rsp_list_committed = commit_ff;
   assign rsp_read_advanced  = swap_ff;
   assign rsp_read_buffer    = rbuf_ff;
   assign rsp_read_count     = rcnt_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff[0] <= dlsr_pkg::LEN_W'(dlsr_pkg::MAX_INSTR) &&
      len_ff[1] <= dlsr_pkg::LEN_W'(dlsr_pkg::MAX_INSTR) &&
      len_ff[2] <= dlsr_pkg::LEN_W'(dlsr_pkg::MAX_INSTR))
      else $error("list length beyond limit");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff != 2'd3 && wr_ptr_ff != 2'd3)
      else $error("buffer pointer out of range");
   a_string_in_list: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dlsr_pkg::PH_SLOT || phase_ff == dlsr_pkg::PH_BYTES) |-> in_list_ff)
      else $error("string upload outside a list");
   a_frame_no_write: assert property (@(posedge clock) disable iff (reset)
      (pop && head.cmd == dlsr_pkg::CMD_FRAME) |=>
      (kind_ff == dlsr_pkg::KIND_NONE && !commit_ff))
      else $error("frame start produced a write");
`endif

endmodule

FILE: rtl/display_list_stream_receiver.sv
// ----------------------------------------------------------------------------
// display_list_stream_receiver
// result path: an accepted item waits in a queue slot register, then the parser registers its result
// throughput: one item per cycle while rsp_ready does not hold a result back, set by the parser step
// a two-entry queue lets the front keep taking items while a result waits
// reset: synchronous; tokens return to 1, 2, 3, all buffers empty
// ----------------------------------------------------------------------------
module display_list_stream_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [dlsr_pkg::WORD_W-1:0]   req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dlsr_pkg::KIND_W-1:0]   rsp_write_kind,
   output logic [dlsr_pkg::PTR_W-1:0]    rsp_target_buffer,
   output logic [dlsr_pkg::LEN_W-1:0]    rsp_instr_slot,
   output logic [2:0]                    rsp_param_slot,
   output logic [dlsr_pkg::SEL_W-1:0]    rsp_string_slot,
   output logic [dlsr_pkg::BC_W-1:0]     rsp_char_pos,
   output logic [dlsr_pkg::WORD_W-1:0]   rsp_write_value,
   output logic                          rsp_list_committed,
   output logic                          rsp_read_advanced,
   output logic [dlsr_pkg::PTR_W-1:0]    rsp_read_buffer,
   output logic [dlsr_pkg::LEN_W-1:0]    rsp_read_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dlsr_pkg::CSR_W-1:0]    csr_index,
   input  logic [dlsr_pkg::WORD_W-1:0]   csr_data
);

   logic                q_push;
   logic                q_ready;
   logic                q_pop;
   logic                q_head_valid;
   dlsr_pkg::entry_type q_entry;
   dlsr_pkg::entry_type q_head;

   dlsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   dlsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   dlsr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (q_head_valid),
      .head               (q_head),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_write_kind     (rsp_write_kind),
      .rsp_target_buffer  (rsp_target_buffer),
      .rsp_instr_slot     (rsp_instr_slot),
      .rsp_param_slot     (rsp_param_slot),
      .rsp_string_slot    (rsp_string_slot),
      .rsp_char_pos       (rsp_char_pos),
      .rsp_write_value    (rsp_write_value),
      .rsp_list_committed (rsp_list_committed),
      .rsp_read_advanced  (rsp_read_advanced),
      .rsp_read_buffer    (rsp_read_buffer),
      .rsp_read_count     (rsp_read_count)
   );

endmodule
